>>> src/irpe_pkg.sv
`default_nettype none

package irpe_pkg;

   // Protocol selector carried by a request.
   typedef enum logic [1:0] {
      MODE_NEC     = 2'd0,
      MODE_SAMSUNG = 2'd1,
      MODE_SONY    = 2'd2,
      MODE_UNSUP   = 2'd3
   } mode_type;

   localparam int CODE_W  = 32;
   localparam int COUNT_W = 6;
   localparam int MARK_W  = 14;
   localparam int SPACE_W = 13;
   localparam int KHZ_W   = 6;

   // Durations in microseconds.
   localparam logic [MARK_W-1:0]  NEC_HDR_MARK   = 14'd9000;
   localparam logic [MARK_W-1:0]  SAM_HDR_MARK   = 14'd4500;
   localparam logic [SPACE_W-1:0] NEC_HDR_SPACE  = 13'd4500;
   localparam logic [MARK_W-1:0]  NEC_BIT_MARK   = 14'd560;
   localparam logic [SPACE_W-1:0] NEC_ONE_SPACE  = 13'd1690;
   localparam logic [SPACE_W-1:0] NEC_ZERO_SPACE = 13'd560;
   localparam logic [MARK_W-1:0]  SONY_HDR_MARK  = 14'd2400;
   localparam logic [SPACE_W-1:0] SONY_SPACE     = 13'd600;
   localparam logic [MARK_W-1:0]  SONY_ONE_MARK  = 14'd1200;
   localparam logic [MARK_W-1:0]  SONY_ZERO_MARK = 14'd600;

   // Carrier frequencies (38000 Hz and 40000 Hz) in kHz.
   localparam logic [KHZ_W-1:0] NEC_KHZ  = 6'd38;
   localparam logic [KHZ_W-1:0] SONY_KHZ = 6'd40;

   // A classified request as it waits between front and back.
   typedef struct packed {
      mode_type              mode;
      logic [CODE_W-1:0]     code;
      logic [COUNT_W-1:0]    count;
   } cmd_type;

endpackage

`default_nettype wire

>>> src/irpe_if.sv
`default_nettype none

interface irpe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] code_value;
   logic [5:0]  bit_count;

   modport source (output valid, output mode, output code_value, output bit_count,
                   input ready);
   modport sink (input valid, input mode, input code_value, input bit_count,
                 output ready);
endinterface

interface irpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] mark_us;
   logic [12:0] space_us;
   logic [5:0]  carrier_khz;
   logic        unsupported;
   logic        last_pair;

   modport source (output valid, output mark_us, output space_us, output carrier_khz,
                   output unsupported, output last_pair, input ready);
   modport sink (input valid, input mark_us, input space_us, input carrier_khz,
                 input unsupported, input last_pair, output ready);
endinterface

`default_nettype wire

>>> src/irpe_front.sv
`default_nettype none

module irpe_front #(
   parameter int MAX_BITS = 32
) (
   irpe_req_if.sink          req_bus,
   output logic              push_valid,
   input  logic              push_ready,
   output irpe_pkg::cmd_type push_cmd
);
   import irpe_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_BITS);

   logic count_bad;

   // A zero count or one beyond the limit sends the full limit.
   assign count_bad = (req_bus.bit_count == '0) || (req_bus.bit_count > MAX_CNT);

   always_comb begin
      push_cmd.mode  = mode_type'(req_bus.mode);
      push_cmd.code  = req_bus.code_value;
      push_cmd.count = count_bad ? MAX_CNT : req_bus.bit_count;
   end

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule

`default_nettype wire

>>> src/irpe_queue.sv
`default_nettype none

module irpe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  irpe_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output irpe_pkg::cmd_type pop_cmd
);
   import irpe_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> src/irpe_back.sv
`default_nettype none

module irpe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  irpe_pkg::cmd_type pop_cmd,
   irpe_rsp_if.source        rsp_bus
);
   import irpe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_BITS    = 3'b010,
      ST_TRAILER = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [COUNT_W-1:0] left_ff, left_in;

   logic               vld_ff, vld_in;
   logic [MARK_W-1:0]  mark_ff, mark_in;
   logic [SPACE_W-1:0] space_ff, space_in;
   logic [KHZ_W-1:0]   khz_ff, khz_in;
   logic               unsup_ff, unsup_in;
   logic               last_ff, last_in;

   logic out_free, emit, last_bit;

   assign out_free  = !vld_ff || rsp_bus.ready;
   assign last_bit  = (left_ff == COUNT_W'(1));
   assign pop_ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      code_in  = code_ff;
      left_in  = left_ff;
      mark_in  = mark_ff;
      space_in = space_ff;
      khz_in   = khz_ff;
      unsup_in = unsup_ff;
      last_in  = last_ff;
      emit     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid && out_free) begin
               emit     = 1'b1;
               mode_in  = pop_cmd.mode;
               code_in  = pop_cmd.code;
               left_in  = pop_cmd.count;
               unsup_in = 1'b0;
               last_in  = 1'b0;
               state_in = ST_BITS;
               unique case (pop_cmd.mode)
                  MODE_NEC: begin
                     mark_in  = NEC_HDR_MARK;
                     space_in = NEC_HDR_SPACE;
                     khz_in   = NEC_KHZ;
                  end
                  MODE_SAMSUNG: begin
                     mark_in  = SAM_HDR_MARK;
                     space_in = NEC_HDR_SPACE;
                     khz_in   = NEC_KHZ;
                  end
                  MODE_SONY: begin
                     mark_in  = SONY_HDR_MARK;
                     space_in = SONY_SPACE;
                     khz_in   = SONY_KHZ;
                  end
                  default: begin
                     mark_in  = '0;
                     space_in = '0;
                     khz_in   = '0;
                     unsup_in = 1'b1;
                     last_in  = 1'b1;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BITS: begin
            if (out_free) begin
               emit    = 1'b1;
               code_in = code_ff >> 1;
               left_in = left_ff - COUNT_W'(1);
               if (mode_ff == MODE_SONY) begin
                  mark_in  = code_ff[0] ? SONY_ONE_MARK : SONY_ZERO_MARK;
                  space_in = last_bit ? '0 : SONY_SPACE;
                  last_in  = last_bit;
                  if (last_bit) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  mark_in  = NEC_BIT_MARK;
                  space_in = code_ff[0] ? NEC_ONE_SPACE : NEC_ZERO_SPACE;
                  last_in  = 1'b0;
                  if (last_bit) begin
                     state_in = ST_TRAILER;
                  end
               end
            end
         end
         ST_TRAILER: begin
            if (out_free) begin
               emit     = 1'b1;
               mark_in  = NEC_BIT_MARK;
               space_in = '0;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      vld_in = emit ? 1'b1 : (vld_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      code_ff  <= code_in;
      left_ff  <= left_in;
      mark_ff  <= mark_in;
      space_ff <= space_in;
      khz_ff   <= khz_in;
      unsup_ff <= unsup_in;
      last_ff  <= last_in;
   end

   assign rsp_bus.valid       = vld_ff;
   assign rsp_bus.mark_us     = mark_ff;
   assign rsp_bus.space_us    = space_ff;
   assign rsp_bus.carrier_khz = khz_ff;
   assign rsp_bus.unsupported = unsup_ff;
   assign rsp_bus.last_pair   = last_ff;

endmodule

`default_nettype wire

>>> src/ir_remote_pulse_encoder.sv
// A request passes the queue and the output register before its header pair is valid.
// A burst holds count+2 pairs for NEC and Samsung, count+1 for Sony and one for an
// unsupported mode, at most 34; the pair sequencer emits one pair a cycle unless stalled.
// Bursts follow one another with no gap while the two-entry request queue holds work.
// Reset is synchronous and active high; it empties the queue and the output register.
`default_nettype none

module ir_remote_pulse_encoder #(
   parameter int MAX_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   irpe_req_if.sink   req_bus,
   irpe_rsp_if.source rsp_bus
);
   import irpe_pkg::*;

   // The front stage normalizes the bit count and types the protocol mode.
   // Its output goes straight into a two-entry queue, so a new request
   // transaction can be taken while the back end is still emitting a burst.
   logic    push_valid, push_ready;
   cmd_type push_cmd;

   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   irpe_front #(
      .MAX_BITS (MAX_BITS)
   ) u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   irpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // The back end pops one command, loads the header pair in the same cycle,
   // then shifts the code word one bit per pair and closes NEC and Samsung
   // bursts with a trailer. Every pair lands in an output register, and the
   // sequencer advances only when that register is empty or being drained,
   // so a stalled result transaction simply freezes the burst.
   irpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import irpe_pkg::*;

   // Burst timing in microseconds and carrier frequencies in kHz, kept local so
   // that a wrong constant in the design package shows up as a mismatch.
   localparam int BIT_LIMIT = 32;
   localparam logic [13:0] NEC_LEAD_MARK     = 14'd9000;
   localparam logic [13:0] SAMSUNG_LEAD_MARK = 14'd4500;
   localparam logic [12:0] NEC_LEAD_SPACE    = 13'd4500;
   localparam logic [13:0] PULSE_MARK        = 14'd560;
   localparam logic [12:0] ONE_GAP           = 13'd1690;
   localparam logic [12:0] ZERO_GAP          = 13'd560;
   localparam logic [13:0] SONY_LEAD_MARK    = 14'd2400;
   localparam logic [12:0] SONY_GAP          = 13'd600;
   localparam logic [13:0] SONY_ONE_WIDTH    = 14'd1200;
   localparam logic [13:0] SONY_ZERO_WIDTH   = 14'd600;
   localparam logic [5:0]  CARRIER_38K       = 6'd38;
   localparam logic [5:0]  CARRIER_40K       = 6'd40;

   // Cycles without any transaction on either channel before the run is
   // declared hung. The slowest healthy stretch is a receiver stall at the
   // high idle rate, which stays far below this.
   localparam int HANG_LIMIT = 5000;
   // Settling time after the last pair: one burst at full length and then some.
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      mode_type    mode;
      logic [31:0] code;
      logic [5:0]  count;
      bit          hold;   // Wait until every pending pair has arrived first.
   } ir_code_t;

   typedef struct {
      logic [13:0] mark;
      logic [12:0] space;
      logic [5:0]  khz;
      logic        unsup;
      logic        last;
   } pulse_pair_t;

   logic clock;
   logic reset;

   irpe_req_if req_if ();
   irpe_rsp_if rsp_if ();

   ir_remote_pulse_encoder #(.MAX_BITS(BIT_LIMIT)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   ir_code_t    codes_to_send[$];
   pulse_pair_t pulse_pairs_due[$];

   int error_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 11;
   int rsp_idle_pct = 87;
   logic req_fire = 1'b0;
   ir_code_t next_code;

   // The clock starts low and toggles every nanosecond.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Expands one code into the mark/space pairs that the encoder must emit.
   // NEC and Samsung send a lead pair, one pair per bit and a closing pulse;
   // Sony sends a lead pair and one pair per bit with no gap after the final
   // bit; an unsupported mode yields a single flagged pair.
   task automatic encode_burst(input ir_code_t c);
      int nbits;
      pulse_pair_t p;
      nbits = (c.count == 0 || c.count > BIT_LIMIT) ? BIT_LIMIT : int'(c.count);
      case (c.mode)
         MODE_NEC, MODE_SAMSUNG: begin
            p = '{mark: (c.mode == MODE_NEC) ? NEC_LEAD_MARK : SAMSUNG_LEAD_MARK,
                  space: NEC_LEAD_SPACE, khz: CARRIER_38K, unsup: 1'b0, last: 1'b0};
            pulse_pairs_due.push_back(p);
            for (int i = 0; i < nbits; i++) begin
               p = '{mark: PULSE_MARK, space: c.code[i] ? ONE_GAP : ZERO_GAP,
                     khz: CARRIER_38K, unsup: 1'b0, last: 1'b0};
               pulse_pairs_due.push_back(p);
            end
            p = '{mark: PULSE_MARK, space: 13'd0, khz: CARRIER_38K,
                  unsup: 1'b0, last: 1'b1};
            pulse_pairs_due.push_back(p);
         end
         MODE_SONY: begin
            p = '{mark: SONY_LEAD_MARK, space: SONY_GAP, khz: CARRIER_40K,
                  unsup: 1'b0, last: 1'b0};
            pulse_pairs_due.push_back(p);
            for (int i = 0; i < nbits; i++) begin
               p = '{mark: c.code[i] ? SONY_ONE_WIDTH : SONY_ZERO_WIDTH,
                     space: (i + 1 < nbits) ? SONY_GAP : 13'd0,
                     khz: CARRIER_40K, unsup: 1'b0, last: (i + 1 == nbits)};
               pulse_pairs_due.push_back(p);
            end
         end
         default: begin
            p = '{mark: 14'd0, space: 13'd0, khz: 6'd0, unsup: 1'b1, last: 1'b1};
            pulse_pairs_due.push_back(p);
         end
      endcase
   endtask

   task automatic queue_code(input mode_type mode, input logic [31:0] code,
                             input logic [5:0] count, input bit hold);
      ir_code_t c;
      c = '{mode: mode, code: code, count: count, hold: hold};
      codes_to_send.push_back(c);
   endtask

   // Random codes lean toward the supported protocols; the bit count mixes
   // short bursts, full bursts, zero and counts past the limit.
   task automatic queue_random_code();
      int pick;
      mode_type mode;
      logic [5:0] count;
      pick = $urandom_range(99);
      if (pick < 30) mode = MODE_NEC;
      else if (pick < 60) mode = MODE_SAMSUNG;
      else if (pick < 90) mode = MODE_SONY;
      else mode = MODE_UNSUP;
      pick = $urandom_range(99);
      if (pick < 35) count = 6'($urandom_range(1, 8));
      else if (pick < 70) count = 6'($urandom_range(1, 32));
      else if (pick < 80) count = 6'd0;
      else count = 6'($urandom_range(33, 63));
      queue_code(mode, $urandom, count, $urandom_range(99) < 3);
   endtask

   // Request driver: changes happen at the falling edge. A presented code
   // stays put until the rising edge accepts it; req_fire tells the driver
   // that the previous edge took the transaction.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (codes_to_send.size() != 0 &&
             (!codes_to_send[0].hold || pulse_pairs_due.size() == 0) &&
             $urandom_range(99) >= send_idle_pct) begin
            next_code = codes_to_send.pop_front();
            req_if.mode       <= next_code.mode;
            req_if.code_value <= next_code.code;
            req_if.bit_count  <= next_code.count;
            req_if.valid      <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // The receiver withholds ready at random, also at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Monitor: at each rising edge an accepted request is expanded into its
   // pairs, and an accepted result is checked against the oldest pending pair.
   always @(posedge clock) begin
      ir_code_t seen;
      pulse_pair_t want;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         seen.mode  = mode_type'(req_if.mode);
         seen.code  = req_if.code_value;
         seen.count = req_if.bit_count;
         seen.hold  = 1'b0;
         encode_burst(seen);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pulse_pairs_due.size() == 0) begin
            flag_mismatch($sformatf("pair %0d/%0d with nothing pending",
                                    rsp_if.mark_us, rsp_if.space_us));
         end else begin
            want = pulse_pairs_due.pop_front();
            if (rsp_if.mark_us !== want.mark)
               flag_mismatch($sformatf("mark_us %0d, predicted %0d",
                                       rsp_if.mark_us, want.mark));
            if (rsp_if.space_us !== want.space)
               flag_mismatch($sformatf("space_us %0d, predicted %0d",
                                       rsp_if.space_us, want.space));
            if (rsp_if.carrier_khz !== want.khz)
               flag_mismatch($sformatf("carrier_khz %0d, predicted %0d",
                                       rsp_if.carrier_khz, want.khz));
            if (rsp_if.unsupported !== want.unsup)
               flag_mismatch($sformatf("unsupported %b, predicted %b",
                                       rsp_if.unsupported, want.unsup));
            if (rsp_if.last_pair !== want.last)
               flag_mismatch($sformatf("last_pair %b, predicted %b",
                                       rsp_if.last_pair, want.last));
         end
      end
   end

   // Watchdog: counts cycles in which neither channel completes a transaction.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.mode       = MODE_NEC;
      req_if.code_value = 32'd0;
      req_if.bit_count  = 6'd0;
      rsp_if.ready      = 1'b0;
      reset             = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: an eager sender against a receiver that mostly stalls.
      // The directed codes cover field extremes, every protocol, counts of
      // zero and past the limit, code bits above the count, and the
      // unsupported mode.
      send_idle_pct = 11;
      rsp_idle_pct  = 87;
      queue_code(MODE_NEC,     32'h0000_0000, 6'd32, 1'b1);
      queue_code(MODE_NEC,     32'hFFFF_FFFF, 6'd32, 1'b0);
      queue_code(MODE_SAMSUNG, 32'h0000_0001, 6'd1,  1'b0);
      queue_code(MODE_SAMSUNG, 32'hA5A5_A5A5, 6'd0,  1'b0);
      queue_code(MODE_NEC,     32'h1234_5678, 6'd33, 1'b0);
      queue_code(MODE_NEC,     32'h8000_0001, 6'd63, 1'b0);
      queue_code(MODE_SONY,    32'h0000_0000, 6'd1,  1'b0);
      queue_code(MODE_SONY,    32'h0000_0001, 6'd1,  1'b0);
      queue_code(MODE_SONY,    32'h0000_0A90, 6'd12, 1'b0);
      queue_code(MODE_SONY,    32'hFFFF_FFFF, 6'd32, 1'b0);
      queue_code(MODE_SONY,    32'h5A5A_5A5A, 6'd0,  1'b0);
      queue_code(MODE_SONY,    32'h8000_0000, 6'd63, 1'b0);
      queue_code(MODE_UNSUP,   32'hFFFF_FFFF, 6'd63, 1'b0);
      queue_code(MODE_UNSUP,   32'h0000_0000, 6'd0,  1'b0);
      queue_code(MODE_NEC,     32'hFFFF_FF00, 6'd8,  1'b0);
      queue_code(MODE_SAMSUNG, 32'hFFFF_FFFE, 6'd31, 1'b0);
      queue_code(MODE_SONY,    32'hFFFF_F000, 6'd12, 1'b0);
      queue_code(MODE_SAMSUNG, 32'h7FFF_FFFF, 6'd32, 1'b0);
      queue_code(MODE_UNSUP,   32'h1357_9BDF, 6'd5,  1'b0);
      queue_code(MODE_NEC,     32'h0000_0002, 6'd2,  1'b0);
      repeat (70) queue_random_code();
      while (codes_to_send.size() != 0) @(posedge clock);

      // Phase two: the sender mostly idles and the receiver rarely stalls.
      // The first code waits for the previous bursts to finish completely.
      send_idle_pct = 87;
      rsp_idle_pct  = 11;
      queue_code(MODE_SONY, $urandom, 6'd20, 1'b1);
      repeat (80) queue_random_code();
      while (codes_to_send.size() != 0) @(posedge clock);

      // Phase three: no idling on either side, bursts back to back.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      queue_code(MODE_NEC, $urandom, 6'd32, 1'b1);
      repeat (80) queue_random_code();

      // Wait for the last code to be taken and every pair to come back, then
      // give the encoder time to show any stray output.
      while (codes_to_send.size() != 0 || req_if.valid) @(posedge clock);
      while (pulse_pairs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
